// ===== src/dhs_pkg.sv =====
// Disk head scheduler package: codes, states and shared types.
// No dependencies; used by dhs_cfg and disk_head_scheduler.
package dhs_pkg;

  localparam int unsigned FIELD_TRACK_W = 16;
  localparam int unsigned TOTAL_W       = 24;
  localparam int unsigned CFG_ADDR_W    = 3;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_RUN   = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ALG_FCFS  = 2'd0,
    ALG_SSTF  = 2'd1,
    ALG_SCAN  = 2'd2,
    ALG_CLOOK = 2'd3
  } alg_t;

  typedef enum logic [1:0] {
    PH_UP,
    PH_DOWN,
    PH_ALL
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EMPTY,
    S_FETCH,
    S_FDATA,
    S_SCAN,
    S_PICK,
    S_SERVE
  } state_t;

  localparam logic [CFG_ADDR_W-1:0] ADDR_START_HEAD = 3'h0;
  localparam logic [CFG_ADDR_W-1:0] ADDR_MAX_TRACK  = 3'h4;

  localparam logic [FIELD_TRACK_W-1:0] MAX_TRACK_RESET = 16'd199;

  typedef struct packed {
    logic [FIELD_TRACK_W-1:0] start_head;
    logic [FIELD_TRACK_W-1:0] max_track;
  } cfg_regs_t;

endpackage

// ===== src/dhs_req_if.sv =====
// Input request channel: valid/ready handshake with func, track and algorithm.
// Depends on nothing.
interface dhs_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] track;
  logic [1:0]  algorithm;

  modport source (output valid, func, track, algorithm, input ready);
  modport sink   (input valid, func, track, algorithm, output ready);
endinterface

// ===== src/dhs_res_if.sv =====
// Result channel: valid/ready handshake with served track and run totals.
// Depends on nothing.
interface dhs_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] served_track;
  logic [23:0] total_movement;
  logic        is_last;
  logic        list_empty;
  logic        dropped_flag;

  modport source (output valid, served_track, total_movement, is_last, list_empty,
                  dropped_flag, input ready);
  modport sink   (input valid, served_track, total_movement, is_last, list_empty,
                  dropped_flag, output ready);
endinterface

// ===== src/dhs_req_mem.sv =====
// Request store: single write port, single read port, registered read data.
// Depends on nothing.
module dhs_req_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 16,
  parameter int unsigned AW    = 5
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== src/dhs_cfg.sv =====
// APB configuration registers: start_head and max_track.
// Depends on dhs_pkg.
module dhs_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [dhs_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  output dhs_pkg::cfg_regs_t                 regs
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.start_head <= '0;
      regs.max_track  <= dhs_pkg::MAX_TRACK_RESET;
    end else if (wr) begin
      unique case (paddr)
        dhs_pkg::ADDR_START_HEAD: regs.start_head <= pwdata[15:0];
        dhs_pkg::ADDR_MAX_TRACK:  regs.max_track  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      dhs_pkg::ADDR_START_HEAD: prdata = {16'd0, regs.start_head};
      dhs_pkg::ADDR_MAX_TRACK:  prdata = {16'd0, regs.max_track};
      default:                  prdata = '0;
    endcase
  end

endmodule

// ===== src/disk_head_scheduler.sv =====
// Disk head scheduler top level: sequencer, selection scan and result register.
// Depends on dhs_pkg, dhs_req_if, dhs_res_if, dhs_req_mem and dhs_cfg.
// A run serves one request per pass: FCFS reads one store entry per result;
// SSTF, SCAN and C-LOOK scan all N stored entries through the single read
// port of the store for each result, plus one extra pass where SCAN or
// C-LOOK turns. New requests are taken only between runs.
module disk_head_scheduler #(
  parameter int unsigned MAX_REQUESTS = 32,
  parameter int unsigned TRACK_BITS   = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  dhs_req_if.sink                        req,
  dhs_res_if.source                      res,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dhs_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int unsigned AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int unsigned CW = $clog2(MAX_REQUESTS + 1);
  localparam int unsigned SW = dhs_pkg::TOTAL_W + 1;

  dhs_pkg::cfg_regs_t regs;
  dhs_pkg::state_t    state, state_next;
  dhs_pkg::phase_t    phase;
  dhs_pkg::alg_t      alg;

  logic [CW-1:0]           count;
  logic                    overflow;
  logic [CW-1:0]           served;
  logic [CW-1:0]           issue;
  logic                    cmp_vld;
  logic [AW-1:0]           cmp_idx;
  logic                    found;
  logic [TRACK_BITS-1:0]   best_val;
  logic [TRACK_BITS-1:0]   best_d;
  logic [AW-1:0]           best_idx;
  logic [TRACK_BITS-1:0]   cur;
  logic [dhs_pkg::TOTAL_W-1:0] total;
  logic [MAX_REQUESTS-1:0] visited;

  logic [TRACK_BITS-1:0] start_t, max_t, in_track, rdata;
  logic [AW-1:0]         raddr;
  logic                  we;
  logic                  accept, slot_free, last, res_load;
  logic [TRACK_BITS-1:0] d_cmp, d_srv, d_mov, move_tgt;
  logic                  cand, better;
  logic [SW-1:0]         sum_srv, sum_mov;
  logic [dhs_pkg::TOTAL_W-1:0] total_srv, total_mov;

  dhs_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .regs
  );

  assign start_t  = TRACK_BITS'(regs.start_head);
  assign max_t    = TRACK_BITS'(regs.max_track);
  assign in_track = TRACK_BITS'(req.track);

  assign req.ready = (state == dhs_pkg::S_IDLE);
  assign accept    = req.valid && req.ready;
  assign slot_free = !res.valid || res.ready;
  assign res_load  = slot_free && ((state == dhs_pkg::S_EMPTY) || (state == dhs_pkg::S_SERVE));
  assign we        = accept && (req.func == dhs_pkg::FUNC_ADD) && (count < CW'(MAX_REQUESTS));
  assign raddr     = (state == dhs_pkg::S_FETCH) ? served[AW-1:0] : issue[AW-1:0];
  assign last      = (served + CW'(1)) == count;

  dhs_req_mem #(.DEPTH(MAX_REQUESTS), .WIDTH(TRACK_BITS), .AW(AW)) u_mem (
    .clk, .we, .waddr(count[AW-1:0]), .wdata(in_track), .raddr, .rdata
  );

  assign d_cmp = (cur > rdata) ? cur - rdata : rdata - cur;
  assign d_srv = (cur > best_val) ? cur - best_val : best_val - cur;
  assign move_tgt = max_t;
  assign d_mov = (cur > move_tgt) ? cur - move_tgt : move_tgt - cur;

  assign sum_srv   = {1'b0, total} + SW'(d_srv);
  assign sum_mov   = {1'b0, total} + SW'(d_mov);
  assign total_srv = (sum_srv > SW'(dhs_pkg::TOTAL_MAX)) ? dhs_pkg::TOTAL_MAX
                                                          : sum_srv[dhs_pkg::TOTAL_W-1:0];
  assign total_mov = (sum_mov > SW'(dhs_pkg::TOTAL_MAX)) ? dhs_pkg::TOTAL_MAX
                                                          : sum_mov[dhs_pkg::TOTAL_W-1:0];

  always_comb begin
    cand = !visited[cmp_idx] && ((alg == dhs_pkg::ALG_SSTF) ||
                                 (phase != dhs_pkg::PH_UP) || (rdata >= start_t));
    case (alg)
      dhs_pkg::ALG_SSTF: better = d_cmp < best_d;
      default: better = (phase == dhs_pkg::PH_DOWN) ? (rdata > best_val) : (rdata < best_val);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dhs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      dhs_pkg::S_IDLE: begin
        if (accept && req.func == dhs_pkg::FUNC_RUN) begin
          if (count == '0) begin
            state_next = dhs_pkg::S_EMPTY;
          end else if (req.algorithm == dhs_pkg::ALG_FCFS) begin
            state_next = dhs_pkg::S_FETCH;
          end else begin
            state_next = dhs_pkg::S_SCAN;
          end
        end
      end
      dhs_pkg::S_EMPTY: if (slot_free) state_next = dhs_pkg::S_IDLE;
      dhs_pkg::S_FETCH: state_next = dhs_pkg::S_FDATA;
      dhs_pkg::S_FDATA: state_next = dhs_pkg::S_SERVE;
      dhs_pkg::S_SCAN:  if (issue == count && !cmp_vld) state_next = dhs_pkg::S_PICK;
      dhs_pkg::S_PICK:  state_next = found ? dhs_pkg::S_SERVE : dhs_pkg::S_SCAN;
      dhs_pkg::S_SERVE: begin
        if (slot_free) begin
          if (last) begin
            state_next = dhs_pkg::S_IDLE;
          end else if (alg == dhs_pkg::ALG_FCFS) begin
            state_next = dhs_pkg::S_FETCH;
          end else begin
            state_next = dhs_pkg::S_SCAN;
          end
        end
      end
      default: state_next = dhs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
      cmp_vld  <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      if (res_load) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
      cmp_vld <= (state == dhs_pkg::S_SCAN) && (issue != count);
      unique case (state)
        dhs_pkg::S_IDLE: begin
          if (accept) begin
            case (req.func)
              dhs_pkg::FUNC_ADD: begin
                if (we) count <= count + CW'(1);
                else    overflow <= 1'b1;
              end
              dhs_pkg::FUNC_CLEAR: begin
                count    <= '0;
                overflow <= 1'b0;
              end
              dhs_pkg::FUNC_RUN: begin
                alg     <= dhs_pkg::alg_t'(req.algorithm);
                phase   <= dhs_pkg::PH_UP;
                cur     <= start_t;
                total   <= '0;
                visited <= '0;
                served  <= '0;
                issue   <= '0;
                found   <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        dhs_pkg::S_EMPTY: begin
          if (slot_free) begin
            res.served_track   <= '0;
            res.total_movement <= '0;
            res.is_last        <= 1'b1;
            res.list_empty     <= 1'b1;
            res.dropped_flag   <= overflow;
          end
        end
        dhs_pkg::S_FETCH: ;
        dhs_pkg::S_FDATA: begin
          best_val <= rdata;
          best_idx <= served[AW-1:0];
        end
        dhs_pkg::S_SCAN: begin
          if (issue != count) begin
            cmp_idx <= issue[AW-1:0];
            issue   <= issue + CW'(1);
          end
          if (cmp_vld && cand && (!found || better)) begin
            found    <= 1'b1;
            best_val <= rdata;
            best_d   <= d_cmp;
            best_idx <= cmp_idx;
          end
        end
        dhs_pkg::S_PICK: begin
          if (!found) begin
            issue <= '0;
            if (alg == dhs_pkg::ALG_SCAN) begin
              phase <= dhs_pkg::PH_DOWN;
              total <= total_mov;
              cur   <= move_tgt;
            end else begin
              phase <= dhs_pkg::PH_ALL;
            end
          end
        end
        dhs_pkg::S_SERVE: begin
          if (slot_free) begin
            total              <= total_srv;
            cur                <= best_val;
            visited[best_idx]  <= 1'b1;
            served             <= served + CW'(1);
            issue              <= '0;
            found              <= 1'b0;
            res.served_track   <= 16'(best_val);
            res.total_movement <= total_srv;
            res.is_last        <= last;
            res.list_empty     <= 1'b0;
            res.dropped_flag   <= overflow;
          end
        end
        default: ;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_REQUESTS))
    else $error("request count above capacity");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (state == dhs_pkg::S_SERVE && slot_free && last) |=> state == dhs_pkg::S_IDLE)
    else $error("run did not end after last result");

  a_no_revisit: assert property (@(posedge clk) disable iff (rst)
    (state == dhs_pkg::S_SERVE && alg != dhs_pkg::ALG_FCFS) |-> !visited[best_idx])
    else $error("request served twice");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> state == dhs_pkg::S_IDLE)
    else $error("request taken during a run");

endmodule
